@@ src/qjtg_pkg.sv @@
// ----------------------------------------------------------------------------
// qjtg_pkg : shared types and constants of the quintic joint trajectory unit
// Word widths, fixed-point format, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package qjtg_pkg;

   // joints held in the plan store, and joint ports on the result channel
   localparam int JOINT_COUNT    = 6;
   localparam int NUM_OUT_JOINTS = 6;
   localparam int JOINT_SEL_W    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

   localparam int POS_W      = 32;   // Q3.28 angle
   localparam int DELTA_W    = 33;   // target - start
   localparam int MAG_W      = 32;   // |delta| never exceeds 2^32 - 1
   localparam int COUNT_W    = 16;   // sample index and step count
   localparam int IDX_W      = 3;    // joint_index field
   localparam int OP_W       = 2;

   localparam int FRAC_BITS  = 24;            // Q0.24 blend arithmetic
   localparam int Q24_W      = FRAC_BITS + 1; // holds 0 .. 1.0 inclusive
   localparam int INNER_W    = 28;            // 10 - 15s + 6s^2 in Q.24
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = Q24_W;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;

   localparam int DIV_STEPS  = FRAC_BITS + 1; // one quotient bit per cycle
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [Q24_W-1:0]   ONE_Q24          = Q24_W'(1) << FRAC_BITS;
   localparam logic [COUNT_W-1:0] STEP_COUNT_RESET = COUNT_W'(800);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_START = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SQUARE,
      ST_CUBE,
      ST_INNER,
      ST_BLEND,
      ST_CLAMP,
      ST_JMUL,
      ST_JACC,
      ST_WRITE
   } seq_state_type;

   // handshake between sequencer and divider
   typedef struct packed {
      logic                 start;
      logic [COUNT_W-1:0]   dividend;
      logic [COUNT_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [Q24_W-1:0]     quotient;
   } div_rsp_type;

endpackage

@@ src/qjtg_divider.sv @@
// ----------------------------------------------------------------------------
// qjtg_divider : restoring divider for the sample phase
// Works out s = floor(i * 2^24 / n) for i <= n, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qjtg_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  qjtg_pkg::div_req_type div_req,
   output qjtg_pkg::div_rsp_type div_rsp
);

   localparam int REM_W = qjtg_pkg::COUNT_W + 1;

   logic                              busy_ff;
   logic                              done_ff;
   logic [qjtg_pkg::DIV_CNT_W-1:0]    cnt_ff;
   logic [REM_W-1:0]                  rem_ff;
   logic [qjtg_pkg::Q24_W-1:0]        quot_ff;
   logic [qjtg_pkg::COUNT_W-1:0]      divisor_ff;

   logic                              ge;
   logic [REM_W-1:0]                  rem_sub;

   assign ge      = rem_ff >= {1'b0, divisor_ff};
   assign rem_sub = ge ? (rem_ff - {1'b0, divisor_ff}) : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= qjtg_pkg::DIV_CNT_W'(qjtg_pkg::DIV_STEPS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder stays below the divisor, so the doubled value fits REM_W bits
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= {1'b0, div_req.dividend};
         divisor_ff <= div_req.divisor;
         quot_ff    <= '0;
      end else if (busy_ff) begin
         rem_ff  <= {rem_sub[REM_W-2:0], 1'b0};
         quot_ff <= {quot_ff[qjtg_pkg::Q24_W-2:0], ge};
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

`ifndef SYNTHESIS
   a_quot_le_one : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (quot_ff <= qjtg_pkg::ONE_Q24))
      else $error("divider phase above one");
`endif

endmodule

@@ src/qjtg_multiplier.sv @@
// ----------------------------------------------------------------------------
// qjtg_multiplier : shared unsigned multiplier with registered product
// Serves the s^2, s^3, blend and per-joint scaling products in turn.
// ----------------------------------------------------------------------------
module qjtg_multiplier (
   input  logic                              clock,
   input  logic [qjtg_pkg::MUL_A_W-1:0]      mul_a,
   input  logic [qjtg_pkg::MUL_B_W-1:0]      mul_b,
   output logic [qjtg_pkg::PROD_W-1:0]       product
);

   logic [qjtg_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= qjtg_pkg::PROD_W'(mul_a) * qjtg_pkg::PROD_W'(mul_b);
   end

   assign product = product_ff;

endmodule

@@ src/quintic_joint_trajectory_generator_unit.sv @@
// ----------------------------------------------------------------------------
// quintic_joint_trajectory_generator_unit : rest-to-rest quintic setpoints
// Six joints follow pos = start + delta * (10s^3 - 15s^4 + 6s^5), s = i/N.
// ----------------------------------------------------------------------------
// Use: the req channel carries one beat per command. A load beat stores the
// start and target of one joint, a start beat arms the move and clears the
// sample counter, and each tick beat while a move is armed produces one rsp
// beat with all six joint positions, the sample number and a last flag.
// Ticks while idle and unknown operation codes are taken and dropped.
// Load and start beats take effect at the edge that accepts them. A tick runs
// through the sequencer states in order: the phase divider is started and its
// 25 quotient bits pulled, the three blend products go through the shared
// multiplier and are clamped, each joint takes a multiply and an accumulate on
// that same multiplier, and the output register is loaded. req_ready is low
// while a tick is being worked on, so no new beat is taken before the tick has
// reached the output register.
// The result sits in an output register; while the receiver stalls the block
// still takes load and start beats, and a finished tick waits for the
// register to free up. csr_step_count is always ready; a tick already taken
// keeps the count it started with. Reset (synchronous) clears the plans,
// stops the move and sets the step count to 800.
// ----------------------------------------------------------------------------
module quintic_joint_trajectory_generator_unit (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [qjtg_pkg::OP_W-1:0]           req_operation,
   input  logic [qjtg_pkg::IDX_W-1:0]          req_joint_index,
   input  logic signed [qjtg_pkg::POS_W-1:0]   req_start_position,
   input  logic signed [qjtg_pkg::POS_W-1:0]   req_target_position,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [qjtg_pkg::POS_W-1:0]   rsp_joint0_position,
   output logic signed [qjtg_pkg::POS_W-1:0]   rsp_joint1_position,
   output logic signed [qjtg_pkg::POS_W-1:0]   rsp_joint2_position,
   output logic signed [qjtg_pkg::POS_W-1:0]   rsp_joint3_position,
   output logic signed [qjtg_pkg::POS_W-1:0]   rsp_joint4_position,
   output logic signed [qjtg_pkg::POS_W-1:0]   rsp_joint5_position,
   output logic [qjtg_pkg::COUNT_W-1:0]        rsp_sample_number,
   output logic                                rsp_last_sample,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qjtg_pkg::COUNT_W-1:0]        csr_step_count
);

   localparam int SUM_W = qjtg_pkg::POS_W + 2;
   localparam int Q_W   = qjtg_pkg::PROD_W - qjtg_pkg::FRAC_BITS;
   localparam int IN_W  = qjtg_pkg::INNER_W + 2;

   // -------------------------------------------------------------------------
   // helpers
   // -------------------------------------------------------------------------
   function automatic logic [qjtg_pkg::INNER_W-1:0] inner_q24(
      input logic [qjtg_pkg::Q24_W-1:0] s,
      input logic [qjtg_pkg::Q24_W-1:0] s2
   );
      logic signed [IN_W-1:0] s_x;
      logic signed [IN_W-1:0] s2_x;
      logic signed [IN_W-1:0] acc;
      s_x  = signed'(IN_W'(s));
      s2_x = signed'(IN_W'(s2));
      acc  = signed'(IN_W'(10) << qjtg_pkg::FRAC_BITS)
             - ((s_x <<< 4) - s_x) + ((s2_x <<< 2) + (s2_x <<< 1));
      if (acc < 0) begin
         inner_q24 = '0;
      end else begin
         inner_q24 = acc[qjtg_pkg::INNER_W-1:0];
      end
   endfunction

   function automatic logic signed [qjtg_pkg::POS_W-1:0] saturate(
      input logic signed [SUM_W-1:0] v
   );
      logic [2:0] top;
      top = v[SUM_W-1:SUM_W-3];
      if (top == 3'b000 || top == 3'b111) begin
         saturate = v[qjtg_pkg::POS_W-1:0];
      end else if (top[2] == 1'b0) begin
         saturate = {1'b0, {(qjtg_pkg::POS_W-1){1'b1}}};
      end else begin
         saturate = {1'b1, {(qjtg_pkg::POS_W-1){1'b0}}};
      end
   endfunction

   // -------------------------------------------------------------------------
   // state
   // -------------------------------------------------------------------------
   qjtg_pkg::seq_state_type                   state_ff, state_in;

   logic signed [qjtg_pkg::POS_W-1:0]         start_ff [qjtg_pkg::JOINT_COUNT];
   logic signed [qjtg_pkg::DELTA_W-1:0]       delta_ff [qjtg_pkg::JOINT_COUNT];
   logic signed [qjtg_pkg::POS_W-1:0]         work_pos_ff [qjtg_pkg::JOINT_COUNT];
   logic signed [qjtg_pkg::POS_W-1:0]         rsp_pos_ff [qjtg_pkg::NUM_OUT_JOINTS];

   logic [qjtg_pkg::COUNT_W-1:0]              step_ff;
   logic [qjtg_pkg::COUNT_W-1:0]              cnt_ff;
   logic                                      active_ff;
   logic [qjtg_pkg::COUNT_W-1:0]              sample_ff;
   logic                                      last_ff;
   logic                                      rsp_valid_ff;
   logic [qjtg_pkg::COUNT_W-1:0]              rsp_sample_ff;
   logic                                      rsp_last_ff;

   logic [qjtg_pkg::Q24_W-1:0]                s2_ff;
   logic [qjtg_pkg::Q24_W-1:0]                s3_ff;
   logic [qjtg_pkg::INNER_W-1:0]              inner_ff;
   logic [qjtg_pkg::Q24_W-1:0]                blend_ff;
   logic [qjtg_pkg::JOINT_SEL_W-1:0]          jsel_ff;

   // -------------------------------------------------------------------------
   // datapath wires
   // -------------------------------------------------------------------------
   logic                                      req_fire;
   logic                                      tick_go;
   qjtg_pkg::op_type                          op;
   logic [qjtg_pkg::COUNT_W-1:0]              n_eff;
   logic [qjtg_pkg::COUNT_W:0]                i_raw;
   logic [qjtg_pkg::COUNT_W-1:0]              i_eff;

   qjtg_pkg::div_req_type                     div_req;
   qjtg_pkg::div_rsp_type                     div_rsp;

   logic [qjtg_pkg::MUL_A_W-1:0]              mul_a;
   logic [qjtg_pkg::MUL_B_W-1:0]              mul_b;
   logic [qjtg_pkg::PROD_W-1:0]               product;
   logic [qjtg_pkg::Q24_W-1:0]                prod_q24;
   logic [Q_W-1:0]                            prod_hi;
   logic [Q_W-1:0]                            rounded;
   logic signed [qjtg_pkg::DELTA_W-1:0]       delta_sel;
   logic [qjtg_pkg::MAG_W-1:0]                mag_sel;
   logic signed [SUM_W-1:0]                   step_sum;
   logic                                      out_free;

   assign req_fire = req_valid && req_ready;
   assign op       = qjtg_pkg::op_type'(req_operation);
   assign n_eff    = (step_ff == '0) ? qjtg_pkg::COUNT_W'(1) : step_ff;
   assign i_raw    = {1'b0, cnt_ff} + 1'b1;
   assign i_eff    = (i_raw > {1'b0, n_eff}) ? n_eff : i_raw[qjtg_pkg::COUNT_W-1:0];
   assign tick_go  = req_fire && (op == qjtg_pkg::OP_TICK) && active_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign div_req.start    = tick_go;
   assign div_req.dividend = i_eff;
   assign div_req.divisor  = n_eff;

   qjtg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   qjtg_multiplier u_multiplier (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign prod_q24  = product[qjtg_pkg::FRAC_BITS +: qjtg_pkg::Q24_W];
   assign prod_hi   = product[qjtg_pkg::PROD_W-1:qjtg_pkg::FRAC_BITS];
   // round half away from zero on the magnitude
   assign rounded   = Q_W'((product + (qjtg_pkg::PROD_W'(1) << (qjtg_pkg::FRAC_BITS - 1)))
                           >> qjtg_pkg::FRAC_BITS);
   assign delta_sel = delta_ff[jsel_ff];
   assign mag_sel   = delta_sel[qjtg_pkg::DELTA_W-1]
                      ? qjtg_pkg::MAG_W'(-delta_sel) : qjtg_pkg::MAG_W'(delta_sel);
   assign step_sum  = SUM_W'(start_ff[jsel_ff])
                      + (delta_sel[qjtg_pkg::DELTA_W-1]
                         ? -signed'(SUM_W'(rounded)) : signed'(SUM_W'(rounded)));

   // -------------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qjtg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mul_a     = qjtg_pkg::MUL_A_W'(mag_sel);
      mul_b     = blend_ff;
      unique case (state_ff)
         qjtg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (tick_go) begin
               state_in = qjtg_pkg::ST_DIVIDE;
            end
         end
         qjtg_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = qjtg_pkg::ST_SQUARE;
            end
         end
         qjtg_pkg::ST_SQUARE: begin
            mul_a    = qjtg_pkg::MUL_A_W'(div_rsp.quotient);
            mul_b    = div_rsp.quotient;
            state_in = qjtg_pkg::ST_CUBE;
         end
         qjtg_pkg::ST_CUBE: begin
            mul_a    = qjtg_pkg::MUL_A_W'(div_rsp.quotient);
            mul_b    = prod_q24;
            state_in = qjtg_pkg::ST_INNER;
         end
         qjtg_pkg::ST_INNER: begin
            state_in = qjtg_pkg::ST_BLEND;
         end
         qjtg_pkg::ST_BLEND: begin
            mul_a    = qjtg_pkg::MUL_A_W'(inner_ff);
            mul_b    = s3_ff;
            state_in = qjtg_pkg::ST_CLAMP;
         end
         qjtg_pkg::ST_CLAMP: begin
            state_in = qjtg_pkg::ST_JMUL;
         end
         qjtg_pkg::ST_JMUL: begin
            state_in = qjtg_pkg::ST_JACC;
         end
         qjtg_pkg::ST_JACC: begin
            if (jsel_ff == qjtg_pkg::JOINT_SEL_W'(qjtg_pkg::JOINT_COUNT - 1)) begin
               state_in = qjtg_pkg::ST_WRITE;
            end else begin
               state_in = qjtg_pkg::ST_JMUL;
            end
         end
         qjtg_pkg::ST_WRITE: begin
            if (out_free) begin
               state_in = qjtg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qjtg_pkg::ST_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // control registers: step count, move state, plan store
   // -------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= qjtg_pkg::STEP_COUNT_RESET;
         cnt_ff    <= '0;
         active_ff <= 1'b0;
         for (int k = 0; k < qjtg_pkg::JOINT_COUNT; k++) begin
            start_ff[k] <= '0;
            delta_ff[k] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            step_ff <= csr_step_count;
         end
         if (req_fire) begin
            unique case (op)
               qjtg_pkg::OP_LOAD: begin
                  if ({1'b0, req_joint_index} < (qjtg_pkg::IDX_W + 1)'(qjtg_pkg::JOINT_COUNT))
                  begin
                     start_ff[req_joint_index[qjtg_pkg::JOINT_SEL_W-1:0]] <=
                        req_start_position;
                     delta_ff[req_joint_index[qjtg_pkg::JOINT_SEL_W-1:0]] <=
                        qjtg_pkg::DELTA_W'(req_target_position)
                        - qjtg_pkg::DELTA_W'(req_start_position);
                  end
               end
               qjtg_pkg::OP_START: begin
                  cnt_ff    <= '0;
                  active_ff <= 1'b1;
               end
               qjtg_pkg::OP_TICK: begin
                  if (active_ff) begin
                     cnt_ff <= i_eff;
                     if (i_eff >= n_eff) begin
                        active_ff <= 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // blend factor and joint positions
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (tick_go) begin
         sample_ff <= i_eff;
         last_ff   <= i_eff >= n_eff;
      end
      if (state_ff == qjtg_pkg::ST_CUBE) begin
         s2_ff <= prod_q24;
      end
      if (state_ff == qjtg_pkg::ST_INNER) begin
         s3_ff    <= prod_q24;
         inner_ff <= inner_q24(div_rsp.quotient, s2_ff);
      end
      if (state_ff == qjtg_pkg::ST_CLAMP) begin
         blend_ff <= (prod_hi > Q_W'(qjtg_pkg::ONE_Q24)) ? qjtg_pkg::ONE_Q24 : prod_q24;
      end
      if (state_ff == qjtg_pkg::ST_JACC) begin
         work_pos_ff[jsel_ff] <= saturate(step_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jsel_ff <= '0;
      end else if (state_ff == qjtg_pkg::ST_CLAMP) begin
         jsel_ff <= '0;
      end else if (state_ff == qjtg_pkg::ST_JACC &&
                   jsel_ff != qjtg_pkg::JOINT_SEL_W'(qjtg_pkg::JOINT_COUNT - 1)) begin
         jsel_ff <= jsel_ff + 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // output register
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == qjtg_pkg::ST_WRITE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == qjtg_pkg::ST_WRITE && out_free) begin
         rsp_sample_ff <= sample_ff;
         rsp_last_ff   <= last_ff;
         for (int k = 0; k < qjtg_pkg::NUM_OUT_JOINTS; k++) begin
            if (k < qjtg_pkg::JOINT_COUNT) begin
               rsp_pos_ff[k] <= work_pos_ff[k];
            end else begin
               rsp_pos_ff[k] <= '0;
            end
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_joint0_position = rsp_pos_ff[0];
   assign rsp_joint1_position = rsp_pos_ff[1];
   assign rsp_joint2_position = rsp_pos_ff[2];
   assign rsp_joint3_position = rsp_pos_ff[3];
   assign rsp_joint4_position = rsp_pos_ff[4];
   assign rsp_joint5_position = rsp_pos_ff[5];
   assign rsp_sample_number   = rsp_sample_ff;
   assign rsp_last_sample     = rsp_last_ff;

`ifndef SYNTHESIS
   a_tick_starts_divider : assert property (@(posedge clock) disable iff (reset)
      tick_go |=> (state_ff == qjtg_pkg::ST_DIVIDE) && div_rsp.busy)
      else $error("tick beat did not start the phase divider");

   a_last_ends_move : assert property (@(posedge clock) disable iff (reset)
      (state_ff == qjtg_pkg::ST_WRITE && last_ff) |-> !active_ff)
      else $error("move still armed after its last sample");

   a_blend_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == qjtg_pkg::ST_JMUL) |-> (blend_ff <= qjtg_pkg::ONE_Q24))
      else $error("blend factor above one");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top : testbench of the quintic joint trajectory generator unit
// Drives load, start and tick beats with random idling on both channels,
// predicts every setpoint beat in fixed point and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [qjtg_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
   localparam longint UNIT_Q24      = 64'sd1 <<< qjtg_pkg::FRAC_BITS;
   localparam int     SETTLE_CYCLES = 90;
   localparam int     RANDOM_ITEMS  = 1400;

   typedef struct packed {
      logic [qjtg_pkg::NUM_OUT_JOINTS-1:0][qjtg_pkg::POS_W-1:0] pos;
      logic [qjtg_pkg::COUNT_W-1:0]                             sample_number;
      logic                                                     last_sample;
   } setpoint_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic [qjtg_pkg::OP_W-1:0]             req_operation = qjtg_pkg::OP_TICK;
   logic [qjtg_pkg::IDX_W-1:0]            req_joint_index = '0;
   logic signed [qjtg_pkg::POS_W-1:0]     req_start_position = '0;
   logic signed [qjtg_pkg::POS_W-1:0]     req_target_position = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic signed [qjtg_pkg::POS_W-1:0]     rsp_joint0_position, rsp_joint1_position;
   logic signed [qjtg_pkg::POS_W-1:0]     rsp_joint2_position, rsp_joint3_position;
   logic signed [qjtg_pkg::POS_W-1:0]     rsp_joint4_position, rsp_joint5_position;
   logic [qjtg_pkg::COUNT_W-1:0]          rsp_sample_number;
   logic                                  rsp_last_sample;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [qjtg_pkg::COUNT_W-1:0]          csr_step_count = '0;

   logic [qjtg_pkg::NUM_OUT_JOINTS-1:0][qjtg_pkg::POS_W-1:0] seen_pos;

   // predictor state
   logic signed [qjtg_pkg::POS_W-1:0]     plan_start [qjtg_pkg::JOINT_COUNT];
   logic signed [qjtg_pkg::DELTA_W-1:0]   plan_delta [qjtg_pkg::JOINT_COUNT];
   logic [qjtg_pkg::COUNT_W-1:0]          plan_counter;
   logic                                  plan_armed;
   logic [qjtg_pkg::COUNT_W-1:0]          plan_steps;
   setpoint_type                          setpoint_q [$];

   int                          error_count = 0;
   bit                          calm = 1'b0;
   int                          gap_pct = 20;
   int                          stall_pct = 20;
   int                          steps_set = 800;   // test side copy of the effective step count

   quintic_joint_trajectory_generator_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_joint_index     (req_joint_index),
      .req_start_position  (req_start_position),
      .req_target_position (req_target_position),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_joint0_position (rsp_joint0_position),
      .rsp_joint1_position (rsp_joint1_position),
      .rsp_joint2_position (rsp_joint2_position),
      .rsp_joint3_position (rsp_joint3_position),
      .rsp_joint4_position (rsp_joint4_position),
      .rsp_joint5_position (rsp_joint5_position),
      .rsp_sample_number   (rsp_sample_number),
      .rsp_last_sample     (rsp_last_sample),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_step_count      (csr_step_count)
   );

   assign seen_pos = {rsp_joint5_position, rsp_joint4_position, rsp_joint3_position,
                      rsp_joint2_position, rsp_joint1_position, rsp_joint0_position};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint blend_factor(int unsigned i, int unsigned n);
      longint s, s2, s3, inner, b;
      s  = (longint'(i) <<< qjtg_pkg::FRAC_BITS) / longint'(n);
      s2 = (s * s) / UNIT_Q24;
      s3 = (s2 * s) / UNIT_Q24;
      inner = 10 * UNIT_Q24 - 15 * s + 6 * s2;
      if (inner < 0) inner = 0;
      b = (s3 * inner) / UNIT_Q24;
      if (b > UNIT_Q24) b = UNIT_Q24;
      return b;
   endfunction

   // delta * b / 2^24, halves rounded away from zero
   function automatic longint scaled_offset(longint delta, longint b);
      longint mag, q;
      mag = (delta < 0) ? -delta : delta;
      q = (mag * b + (UNIT_Q24 >>> 1)) >>> qjtg_pkg::FRAC_BITS;
      return (delta < 0) ? -q : q;
   endfunction

   task automatic predict_beat(input logic [qjtg_pkg::OP_W-1:0] op,
                               input logic [qjtg_pkg::IDX_W-1:0] idx,
                               input logic signed [qjtg_pkg::POS_W-1:0] st,
                               input logic signed [qjtg_pkg::POS_W-1:0] tg);
      setpoint_type sp;
      int unsigned  n, i;
      longint       b, p;
      if (op == qjtg_pkg::OP_LOAD) begin
         if (idx < qjtg_pkg::JOINT_COUNT) begin
            plan_start[idx] = st;
            plan_delta[idx] = {tg[qjtg_pkg::POS_W-1], tg} - {st[qjtg_pkg::POS_W-1], st};
         end
      end else if (op == qjtg_pkg::OP_START) begin
         plan_counter = '0;
         plan_armed   = 1'b1;
      end else if (op == qjtg_pkg::OP_TICK && plan_armed) begin
         n = (plan_steps == 0) ? 1 : plan_steps;
         i = plan_counter + 1;
         if (i > n) i = n;
         plan_counter = i[qjtg_pkg::COUNT_W-1:0];
         b = blend_factor(i, n);
         sp = '0;
         for (int k = 0; k < qjtg_pkg::NUM_OUT_JOINTS; k++) begin
            p = 0;
            if (k < qjtg_pkg::JOINT_COUNT) begin
               p = longint'(plan_start[k]) + scaled_offset(longint'(plan_delta[k]), b);
               if (p > 64'sd2147483647)  p = 64'sd2147483647;
               if (p < -64'sd2147483648) p = -64'sd2147483648;
            end
            sp.pos[k] = p[qjtg_pkg::POS_W-1:0];
         end
         sp.sample_number = i[qjtg_pkg::COUNT_W-1:0];
         sp.last_sample   = (i >= n);
         if (i >= n) plan_armed = 1'b0;
         setpoint_q.push_back(sp);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < qjtg_pkg::JOINT_COUNT; k++) begin
            plan_start[k] = '0;
            plan_delta[k] = '0;
         end
         plan_counter = '0;
         plan_armed   = 1'b0;
         plan_steps   = qjtg_pkg::STEP_COUNT_RESET;
      end else begin
         if (req_valid && req_ready)
            predict_beat(req_operation, req_joint_index, req_start_position,
                         req_target_position);
         if (csr_valid && csr_ready)
            plan_steps = csr_step_count;
      end
   end

   // ------------------------------------------------------------------ checker
   always @(posedge clock) begin : check_setpoints
      setpoint_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (setpoint_q.size() == 0) begin
            $display("%0t: setpoint beat with none expected, sample %0d", $time,
                     rsp_sample_number);
            error_count++;
         end else begin
            want = setpoint_q.pop_front();
            for (int k = 0; k < qjtg_pkg::NUM_OUT_JOINTS; k++)
               if (seen_pos[k] !== want.pos[k]) begin
                  $display("%0t: joint%0d position expected %0d got %0d", $time, k,
                           $signed(want.pos[k]), $signed(seen_pos[k]));
                  error_count++;
               end
            if (rsp_sample_number !== want.sample_number) begin
               $display("%0t: sample_number expected %0d got %0d", $time,
                        want.sample_number, rsp_sample_number);
               error_count++;
            end
            if (rsp_last_sample !== want.last_sample) begin
               $display("%0t: last_sample expected %0b got %0b", $time,
                        want.last_sample, rsp_last_sample);
               error_count++;
            end
         end
      end
   end

   // receiver stalls in bursts of random length
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------ drivers
   task automatic send_beat(input logic [qjtg_pkg::OP_W-1:0] op,
                            input logic [qjtg_pkg::IDX_W-1:0] idx,
                            input logic [qjtg_pkg::POS_W-1:0] st,
                            input logic [qjtg_pkg::POS_W-1:0] tg);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 13)) @(negedge clock);
      end
      @(negedge clock);
      req_operation       = op;
      req_joint_index     = idx;
      req_start_position  = st;
      req_target_position = tg;
      req_valid           = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_tick();
      send_beat(qjtg_pkg::OP_TICK, qjtg_pkg::IDX_W'($urandom), $urandom, $urandom);
   endtask

   task automatic send_start();
      send_beat(qjtg_pkg::OP_START, qjtg_pkg::IDX_W'($urandom), $urandom, $urandom);
   endtask

   // hold off until every setpoint is in and the unit has gone quiet
   task automatic wait_settled();
      @(negedge clock);
      req_valid = 1'b0;
      while (setpoint_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_steps(input int value);
      wait_settled();
      @(negedge clock);
      csr_step_count = value[qjtg_pkg::COUNT_W-1:0];
      csr_valid      = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      steps_set = (value[qjtg_pkg::COUNT_W-1:0] == 0) ? 1 : value[qjtg_pkg::COUNT_W-1:0];
   endtask

   function automatic logic [qjtg_pkg::POS_W-1:0] pick_angle();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_steps();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return $urandom_range(40, 120);
         default: return $urandom_range(2, 16);
      endcase
   endfunction

   // -------------------------------------------------------------------- tests
   task automatic test_idle_and_ignored();
      send_tick();                                   // idle, nothing comes back
      send_beat(OP_RESERVED, 3'd1, $urandom, $urandom);
      send_beat(qjtg_pkg::OP_LOAD, 3'd6, 32'h1234_5678, 32'h7654_3210);
      send_beat(qjtg_pkg::OP_LOAD, 3'd7, 32'h8000_0000, 32'h7fff_ffff);
      send_start();                                  // reset plans, step count 800
      send_tick();
      send_tick();
   endtask

   task automatic test_full_swing();
      send_beat(qjtg_pkg::OP_LOAD, 3'd0, 32'h8000_0000, 32'h7fff_ffff);
      send_beat(qjtg_pkg::OP_LOAD, 3'd1, 32'h7fff_ffff, 32'h8000_0000);
      send_beat(qjtg_pkg::OP_LOAD, 3'd2, 32'h0000_0000, 32'h7fff_ffff);
      send_beat(qjtg_pkg::OP_LOAD, 3'd3, 32'h8000_0000, 32'h0000_0000);
      send_beat(qjtg_pkg::OP_LOAD, 3'd4, 32'h7fff_ffff, 32'h7fff_ffff);
      send_beat(qjtg_pkg::OP_LOAD, 3'd5, $urandom, $urandom);
      write_steps(1);
      send_start();
      send_tick();                                   // straight to the target
      send_tick();                                   // move over, idle
      write_steps(0);                                // zero counts as one
      send_start();
      send_tick();
   endtask

   task automatic test_lowered_count();
      write_steps(16'hffff);
      send_start();
      send_tick();
      send_beat(qjtg_pkg::OP_LOAD, 3'd2, pick_angle(), pick_angle());  // from next tick
      send_tick();
      send_tick();
      write_steps(2);                                // counter now beyond N
      send_tick();
      send_start();
      send_tick();
      send_start();                                  // restart mid-move
      send_tick();
      send_tick();
   endtask

   task automatic test_random_moves();
      int  sent, loads, ticks, t, j;
      bit  left_armed, restarted;
      sent = 0;
      left_armed = 1'b0;
      write_steps(pick_steps());
      while (sent < RANDOM_ITEMS) begin
         if (sent > RANDOM_ITEMS * 9 / 10) calm = 1'b1;
         gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         if ($urandom_range(0, 4) == 0) begin
            write_steps(pick_steps());
            if (left_armed) begin
               send_tick();
               sent++;
            end
         end else if ($urandom_range(0, 9) == 0) begin
            wait_settled();
         end
         loads = $urandom_range(0, 8);
         repeat (loads) begin
            j = $urandom_range(0, 7);
            send_beat(qjtg_pkg::OP_LOAD, j[qjtg_pkg::IDX_W-1:0], pick_angle(),
                      pick_angle());
            if (j < qjtg_pkg::JOINT_COUNT) sent++;
         end
         send_start();
         sent++;
         restarted  = 1'b0;
         left_armed = 1'b1;
         ticks = steps_set;
         if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, steps_set - 1);
         t = 0;
         while (t < ticks) begin
            case ($urandom_range(0, 19))
               0: begin
                  j = $urandom_range(0, 7);
                  send_beat(qjtg_pkg::OP_LOAD, j[qjtg_pkg::IDX_W-1:0], pick_angle(),
                            pick_angle());
                  if (j < qjtg_pkg::JOINT_COUNT) sent++;
               end
               1: send_beat(OP_RESERVED, qjtg_pkg::IDX_W'($urandom), $urandom, $urandom);
               2: begin
                  if (!restarted) begin
                     send_start();
                     sent++;
                     restarted = 1'b1;
                     t = 0;
                  end
               end
               default: begin
                  send_tick();
                  sent++;
                  t++;
               end
            endcase
         end
         if (ticks == steps_set) begin
            left_armed = 1'b0;
            if ($urandom_range(0, 5) == 0) send_tick();   // after the last sample
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_idle_and_ignored();
      test_full_swing();
      test_lowered_count();
      test_random_moves();
      calm = 1'b1;
      wait_settled();
      if (error_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #6ms;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
